@@ sv/psrt_pkg.sv @@
// Package for the point set rotate/translate block.
// Holds the CORDIC angle table, gain constant, opcodes and shared types.
// Depends on nothing.
`default_nettype none
package psrt_pkg;

    localparam int TableLen = 24;
    localparam int CordicW  = 44;
    localparam logic [31:0] InvGain = 32'h9B74EDA8;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_MOVE     = 2'd1,
        OP_MOVE_ALL = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    // One CORDIC job handed from the sequencer to the shared unit.
    typedef struct packed {
        logic                      start;
        logic                      vectoring;
        logic signed [CordicW-1:0] x0;
        logic signed [CordicW-1:0] y0;
        logic [31:0]               z0;
    } cordic_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [CordicW-1:0] x;
        logic signed [CordicW-1:0] y;
        logic [31:0]               z;
    } cordic_rsp_t;

    function automatic logic [31:0] atan_turns(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ sv/psrt_ram.sv @@
// Generic single-port RAM with registered read.
// Depends on nothing.
`default_nettype none
module psrt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Read data is registered and shows the old contents during a write.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

@@ sv/psrt_cordic.sv @@
// Shared iterative CORDIC unit: one micro-rotation per cycle.
// Handles both vectoring and rotation. Depends on psrt_pkg.
`default_nettype none
module psrt_cordic #(
    parameter int STEPS = 16
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire psrt_pkg::cordic_req_t req,
    output psrt_pkg::cordic_rsp_t     rsp
);
    import psrt_pkg::*;

    localparam int NIter = (STEPS < TableLen) ? STEPS : TableLen;

    logic signed [CordicW-1:0] x_reg, x_next, y_reg, y_next;
    logic [31:0]               z_reg, z_next;
    logic [4:0]                i_reg, i_next;
    logic                      busy_reg, busy_next, vec_reg, vec_next;
    logic                      done_reg, done_next;
    logic signed [CordicW-1:0] xs, ys;
    logic                      dir;

    assign xs  = x_reg >>> i_reg;
    assign ys  = y_reg >>> i_reg;
    // Vectoring drives y to zero; rotation drives z to zero.
    assign dir = vec_reg ? (y_reg > 0) : ~z_reg[31];

    always_comb begin
        x_next = x_reg; y_next = y_reg; z_next = z_reg;
        i_next = i_reg; busy_next = busy_reg; vec_next = vec_reg;
        done_next = 1'b0;
        if (req.start) begin
            x_next = req.x0; y_next = req.y0; z_next = req.z0;
            vec_next = req.vectoring; i_next = '0; busy_next = 1'b1;
        end else if (busy_reg) begin
            if (vec_reg) begin
                if (dir) begin
                    x_next = x_reg + ys; y_next = y_reg - xs;
                    z_next = z_reg + atan_turns(i_reg);
                end else begin
                    x_next = x_reg - ys; y_next = y_reg + xs;
                    z_next = z_reg - atan_turns(i_reg);
                end
            end else begin
                if (dir) begin
                    x_next = x_reg - ys; y_next = y_reg + xs;
                    z_next = z_reg - atan_turns(i_reg);
                end else begin
                    x_next = x_reg + ys; y_next = y_reg - xs;
                    z_next = z_reg + atan_turns(i_reg);
                end
            end
            i_next = i_reg + 5'd1;
            if (i_reg == 5'(NIter - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        x_reg <= x_next; y_reg <= y_next; z_reg <= z_next;
        i_reg <= i_next; vec_reg <= vec_next;
    end

    assign rsp.done = done_reg;
    assign rsp.x    = x_reg;
    assign rsp.y    = y_reg;
    assign rsp.z    = z_reg;

    // A finished job always follows a busy phase.
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |-> $past(busy_reg))
        else $error("cordic done without busy");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg)
        else $error("cordic restarted while busy");
    a_done_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done)
        else $error("cordic done held");
endmodule
`default_nettype wire

@@ sv/point_set_rotate_translate.sv @@
// Top level: point table in polar form with an iterative CORDIC sequencer.
// Depends on psrt_pkg, psrt_ram, psrt_cordic.
//
//  channel | direction | ports
//  s_      | in        | s_valid s_ready s_opcode s_point_index s_coord_x/y s_rotation
//  m_      | out       | m_valid m_ready m_out_index m_out_x/y m_out_radius m_out_angle ...
//  cfg     | in        | cfg_we cfg_index cfg_wdata
//
// An add away from the center or a single move runs one job through the shared
// CORDIC unit, which does one micro-rotation per cycle. A move-all scans the slots
// in order up to the last valid one, with one CORDIC job per valid slot.
// Reset clears valid bits and control; the point memories need no clearing.
// A stalled output holds the sequencer; the input is not ready until done.
`default_nettype none
module point_set_rotate_translate #(
    parameter int MAX_POINTS   = 64,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [31:0] cfg_wdata,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [5:0]  s_point_index,
    input  wire logic signed [31:0] s_coord_x,
    input  wire logic signed [31:0] s_coord_y,
    input  wire logic [15:0] s_rotation,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_out_index,
    output logic signed [31:0] m_out_x,
    output logic signed [31:0] m_out_y,
    output logic [31:0]      m_out_radius,
    output logic [15:0]      m_out_angle,
    output logic             m_last,
    output logic             m_status
);
    import psrt_pkg::*;

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_DECODE = 9'b000000010,
        ST_SCAN   = 9'b000000100,
        ST_READ   = 9'b000001000,
        ST_PREP   = 9'b000010000,
        ST_RUN    = 9'b000100000,
        ST_FINV   = 9'b001000000,
        ST_FINR   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0] cx_reg, cy_reg;
    opcode_t            op_reg;
    logic [5:0]         idx_reg;
    logic signed [31:0] ix_reg, iy_reg;
    logic [15:0]        rot_reg;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [MAX_POINTS-1:0] valid_reg;
    logic               seen_reg, seen_next;

    logic [5:0]         o_idx_reg;
    logic signed [31:0] o_x_reg, o_y_reg;
    logic [31:0]        o_r_reg;
    logic [15:0]        o_a_reg;
    logic               o_last_reg, o_st_reg, m_valid_reg;

    // Product register for gain correction (32x32 multiplier).
    logic [63:0]        prod_reg;
    logic [15:0]        ang_reg;

    cordic_req_t req;
    cordic_rsp_t rsp;

    logic           ram_we;
    logic [AW-1:0]  ram_addr;
    logic [31:0]    rad_q;
    logic [15:0]    ang_q;
    logic [31:0]    w_rad;
    logic [15:0]    w_ang;

    psrt_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_rad (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(w_rad), .rdata(rad_q));
    psrt_ram #(.WIDTH(16), .DEPTH(MAX_POINTS)) u_ang (
        .aclk(aclk), .we(ram_we), .addr(ram_addr), .wdata(w_ang), .rdata(ang_q));

    psrt_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .aclk(aclk), .aresetn(aresetn), .req(req), .rsp(rsp));

    assign s_ready = (state_reg == ST_IDLE);

    // Slot validity and last-valid-slot search helpers.
    logic slot_ok, is_last;
    logic [MAX_POINTS-1:0] above_mask;
    always_comb begin
        slot_ok = (int'(idx_reg) < MAX_POINTS);
        for (int k = 0; k < MAX_POINTS; k++) begin
            above_mask[k] = (k > int'(slot_reg));
        end
        is_last = ((valid_reg & above_mask) == '0);
    end

    // Offsets, with a guard bit.
    logic signed [32:0] dx, dy;
    assign dx = 33'(ix_reg) - 33'(cx_reg);
    assign dy = 33'(iy_reg) - 33'(cy_reg);

    // An add at the center stores radius and angle zero without CORDIC.
    logic zero_add;
    assign zero_add = (state_reg == ST_DECODE) && op_reg == OP_ADD && slot_ok &&
                      dx == 0 && dy == 0;

    // Gain-corrected vectoring radius pieces.
    logic [63:0] ux;
    logic [63:0] tsum;
    logic [63:0] trnd;
    assign ux = rsp.x[CordicW-1] ? 64'd0 : 64'(rsp.x);

    // Rotation outputs rounded and translated.
    logic signed [CordicW-1:0] rx, ry;
    logic signed [CordicW:0]   sx, sy;
    logic [31:0] zrot;
    logic [15:0] new_ang;
    assign rx = (rsp.x + CordicW'(128)) >>> 8;
    assign ry = (rsp.y + CordicW'(128)) >>> 8;
    assign sx = (CordicW+1)'(ix_reg) + (CordicW+1)'(rx);
    assign sy = (CordicW+1)'(iy_reg) + (CordicW+1)'(ry);
    assign new_ang = ang_q + rot_reg;
    assign zrot = {ang_reg, 16'd0};

    function automatic logic signed [31:0] sat(input logic signed [CordicW:0] v);
        logic signed [31:0] r;
        if (v > (CordicW+1)'(32'sh7FFFFFFF))       r = 32'sh7FFFFFFF;
        else if (v < -(CordicW+1)'(33'sh80000000))  r = 32'sh80000000;
        else                                        r = v[31:0];
        return r;
    endfunction

    // Multi-phase vectoring correction: lo term then hi term.
    logic [1:0] mph_reg, mph_next;
    logic [63:0] acc_reg, acc_next;

    always_comb begin
        state_next = state_reg;
        slot_next  = slot_reg;
        seen_next  = seen_reg;
        mph_next   = mph_reg;
        acc_next   = acc_reg;
        req        = '0;
        ram_we     = 1'b0;
        ram_addr   = slot_reg;
        w_rad      = '0;
        w_ang      = '0;
        tsum       = acc_reg;
        trnd       = (tsum + 64'h800000) >> 24;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (op_reg == OP_NONE) begin
                    state_next = ST_IDLE;
                end else if (op_reg == OP_MOVE_ALL) begin
                    slot_next = '0;
                    seen_next = 1'b0;
                    state_next = ST_SCAN;
                end else if (!slot_ok || (op_reg == OP_MOVE &&
                             !valid_reg[idx_reg[AW-1:0]])) begin
                    state_next = ST_OUT;
                end else if (op_reg == OP_ADD) begin
                    if (dx == 0 && dy == 0) begin
                        ram_we     = 1'b1;
                        ram_addr   = idx_reg[AW-1:0];
                        state_next = ST_OUT;
                    end else begin
                        req.start     = 1'b1;
                        req.vectoring = 1'b1;
                        req.x0 = dx[32] ? -(CordicW'(dx) <<< 8) : (CordicW'(dx) <<< 8);
                        req.y0 = dx[32] ? -(CordicW'(dy) <<< 8) : (CordicW'(dy) <<< 8);
                        req.z0 = dx[32] ? 32'h80000000 : 32'h0;
                        state_next = ST_RUN;
                    end
                end else begin
                    slot_next = idx_reg[AW-1:0];
                    state_next = ST_READ;
                end
            end
            ST_SCAN: begin
                if (valid_reg[slot_reg]) begin
                    state_next = ST_READ;
                end else if (int'(slot_reg) == MAX_POINTS - 1) begin
                    state_next = seen_reg ? ST_IDLE : ST_OUT;
                end else begin
                    slot_next = slot_reg + 1'b1;
                end
            end
            ST_READ: state_next = ST_PREP;
            ST_PREP: begin
                // ang_q and rad_q now valid; prod_reg computed this cycle.
                state_next = ST_FINR;
                mph_next   = 2'd0;
            end
            ST_FINR: begin
                if (mph_reg == 2'd0) begin
                    mph_next = 2'd1;
                end else begin
                    req.start     = 1'b1;
                    req.vectoring = 1'b0;
                    if (zrot >= 32'h40000000 && zrot < 32'hC0000000) begin
                        req.x0 = -CordicW'(prod_reg >> 24);
                        req.z0 = zrot - 32'h80000000;
                    end else begin
                        req.x0 = CordicW'(prod_reg >> 24);
                        req.z0 = zrot;
                    end
                    req.y0 = '0;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                if (rsp.done) begin
                    if (op_reg == OP_ADD) begin
                        mph_next = 2'd0;
                        state_next = ST_FINV;
                    end else begin
                        ram_we = 1'b1;
                        w_rad  = rad_q;
                        w_ang  = ang_reg;
                        if (op_reg == OP_MOVE_ALL) begin
                            seen_next = 1'b1;
                        end
                        state_next = ST_OUT;
                    end
                end
            end
            ST_FINV: begin
                // Phase 0: lo product; phase 1: hi product; phase 2: write back.
                if (mph_reg == 2'd2) begin
                    ram_we   = 1'b1;
                    ram_addr = idx_reg[AW-1:0];
                    w_rad    = (trnd > 64'hFFFFFFFF) ? 32'hFFFFFFFF : trnd[31:0];
                    w_ang    = 16'((rsp.z + 32'h8000) >> 16);
                    state_next = ST_OUT;
                end else begin
                    mph_next = mph_reg + 2'd1;
                    if (mph_reg == 2'd0) acc_next = (64'(ux[15:0]) * 64'(InvGain)) >> 16;
                    else acc_next = acc_reg + 64'(ux[47:16]) * 64'(InvGain);
                end
            end
            ST_OUT: begin
                if (!m_valid_reg) begin
                    if (op_reg == OP_MOVE_ALL && seen_reg) begin
                        if (is_last || int'(slot_reg) == MAX_POINTS - 1) begin
                            state_next = ST_IDLE;
                        end else begin
                            slot_next = slot_reg + 1'b1;
                            state_next = ST_SCAN;
                        end
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cx_reg      <= '0;
            cy_reg      <= '0;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
            seen_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            seen_reg  <= seen_next;
            if (cfg_we) begin
                if (cfg_index == 1'b0) cx_reg <= cfg_wdata;
                else                   cy_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if ((state_reg == ST_FINV && mph_reg == 2'd2) || zero_add) begin
                valid_reg[idx_reg[AW-1:0]] <= 1'b1;
            end
            // Result beat production.
            if (state_reg == ST_DECODE && state_next == ST_OUT) begin
                m_valid_reg <= 1'b1;
            end
            if (state_reg == ST_SCAN && state_next == ST_OUT) begin
                m_valid_reg <= 1'b1;
            end
            if ((state_reg == ST_RUN && rsp.done && op_reg != OP_ADD) ||
                (state_reg == ST_FINV && mph_reg == 2'd2)) begin
                m_valid_reg <= 1'b1;
            end
        end
        slot_reg <= slot_next;
        mph_reg  <= mph_next;
        acc_reg  <= acc_next;
        if (s_valid && s_ready) begin
            op_reg  <= opcode_t'(s_opcode);
            idx_reg <= s_point_index;
            ix_reg  <= s_coord_x;
            iy_reg  <= s_coord_y;
            rot_reg <= s_rotation;
        end
        if (state_reg == ST_READ) begin
            // Memory read lands next cycle.
        end
        if (state_reg == ST_PREP) begin
            ang_reg  <= new_ang;
            prod_reg <= 64'(rad_q) * 64'(InvGain);
        end
        // Output register loads.
        if (state_reg == ST_DECODE && state_next == ST_OUT) begin
            o_idx_reg <= idx_reg; o_r_reg <= '0; o_a_reg <= '0; o_last_reg <= 1'b1;
            if (zero_add) begin
                o_x_reg <= ix_reg; o_y_reg <= iy_reg; o_st_reg <= 1'b0;
            end else begin
                o_x_reg <= '0; o_y_reg <= '0; o_st_reg <= 1'b1;
            end
        end
        if (state_reg == ST_SCAN && state_next == ST_OUT) begin
            o_idx_reg <= '0; o_x_reg <= '0; o_y_reg <= '0; o_r_reg <= '0;
            o_a_reg <= '0; o_last_reg <= 1'b1; o_st_reg <= 1'b1;
        end
        if (state_reg == ST_RUN && rsp.done && op_reg != OP_ADD) begin
            o_idx_reg <= 6'(slot_reg);
            o_x_reg <= sat(sx); o_y_reg <= sat(sy);
            o_r_reg <= rad_q; o_a_reg <= ang_reg;
            o_last_reg <= (op_reg == OP_MOVE) ? 1'b1 : is_last;
            o_st_reg <= 1'b0;
        end
        if (state_reg == ST_FINV && mph_reg == 2'd2) begin
            o_idx_reg <= idx_reg; o_x_reg <= ix_reg; o_y_reg <= iy_reg;
            o_r_reg <= w_rad; o_a_reg <= w_ang; o_last_reg <= 1'b1;
            o_st_reg <= 1'b0;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_out_index  = o_idx_reg;
    assign m_out_x      = o_x_reg;
    assign m_out_y      = o_y_reg;
    assign m_out_radius = o_r_reg;
    assign m_out_angle  = o_a_reg;
    assign m_last       = o_last_reg;
    assign m_status     = o_st_reg;

    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !s_ready || state_reg == ST_IDLE)
        else $error("ready outside idle");
    a_out_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> m_valid && $stable(m_out_index) && $stable(m_out_x) &&
        $stable(m_out_y) && $stable(m_out_radius) && $stable(m_out_angle))
        else $error("result beat changed while waiting");
    a_status_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status) |-> m_last)
        else $error("error beat not last");
endmodule
`default_nettype wire
